FILE: rtl/gn3_pkg.sv
// Shared constants and codes for the 3D gradient noise core.
// No dependencies; imported by the core, the table RAM users and the checker.
`default_nettype none

package gn3_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int PERM_W   = 8;
    localparam int COORD_W  = 32;
    localparam int IN_TD_W  = 2 * PERM_W + 3 * COORD_W;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/gn3_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies; holds the permutation table copies of the noise core.
`default_nettype none

module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr0,
    input  logic [AW-1:0]    rd_addr1,
    output logic [WIDTH-1:0] rd_data0,
    output logic [WIDTH-1:0] rd_data1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data0_reg;
    logic [WIDTH-1:0] rd_data1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data0_reg <= mem_reg[rd_addr0];
            rd_data1_reg <= mem_reg[rd_addr1];
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

`default_nettype wire

FILE: rtl/gradient_noise_3d_core.sv
// 3D improved gradient noise core: table load, hashed lookups, fade, blend.
// Depends on gn3_pkg and gn3_ram.
//
//  channel  | dir | tuser          | tdata (lowest bit up)
//  s_axis   | in  | operation      | table_index, table_value, coord_x, coord_y, coord_z
//  m_axis   | out | -              | noise_value, zero fill to whole bytes
//
// One request per cycle unless the pipeline holds or a load waits; each sample's result is registered before m_axis.
// A load writes all seven table copies at acceptance and gives no result.
// A load waits while a sample sits in the first two stages, which still read the table.
// The whole pipeline holds while a result waits on m_axis_tready.
// rst_n clears the valid bits only; the table is undefined until loaded.
`default_nettype none

module gradient_noise_3d_core import gn3_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int OUT_W    = FRAC_BITS + 3,
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic                s_axis_tuser,   // operation
    input  logic [IN_TD_W-1:0]  s_axis_tdata,   // table_index, table_value, coord_x, y, z
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_TD_W-1:0] m_axis_tdata    // noise_value, zero fill
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int W  = FRAC_BITS + 6;
    localparam int P  = 2 * W;

    localparam logic signed [W-1:0] ONE     = W'(64'sd1 << FRAC_BITS);
    localparam logic signed [W-1:0] TEN     = W'(64'sd10 << FRAC_BITS);
    localparam logic signed [W-1:0] FIFTEEN = W'(64'sd15 << FRAC_BITS);
    localparam logic signed [W-1:0] LIM     = W'(64'sd2 << FRAC_BITS);

    function automatic logic signed [W-1:0] grad(
        input logic [PERM_W-1:0]  hash,
        input logic signed [W-1:0] gx,
        input logic signed [W-1:0] gy,
        input logic signed [W-1:0] gz
    );
        logic [3:0] h;
        logic signed [W-1:0] gu;
        logic signed [W-1:0] gv;
        h  = hash[3:0];
        gu = (h < 4'd8) ? gx : gy;
        gv = (h < 4'd4) ? gy : ((h == 4'd12 || h == 4'd14) ? gx : gz);
        return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    endfunction

    // input unpack
    logic [PERM_W-1:0]        in_index;
    logic [PERM_W-1:0]        in_value;
    logic signed [COORD_W-1:0] in_cx_full;
    logic signed [COORD_W-1:0] in_cy_full;
    logic signed [COORD_W-1:0] in_cz_full;
    logic [COORD_W-1:0]       in_x;
    logic [COORD_W-1:0]       in_y;
    logic [COORD_W-1:0]       in_z;

    assign in_index   = s_axis_tdata[PERM_W-1:0];
    assign in_value   = s_axis_tdata[2*PERM_W-1:PERM_W];
    assign in_x       = s_axis_tdata[2*PERM_W+COORD_W-1:2*PERM_W];
    assign in_y       = s_axis_tdata[2*PERM_W+2*COORD_W-1:2*PERM_W+COORD_W];
    assign in_z       = s_axis_tdata[2*PERM_W+3*COORD_W-1:2*PERM_W+2*COORD_W];
    assign in_cx_full = $signed(in_x) >>> FRAC_BITS;
    assign in_cy_full = $signed(in_y) >>> FRAC_BITS;
    assign in_cz_full = $signed(in_z) >>> FRAC_BITS;

    // handshake
    logic [9:1] vld_reg;
    logic       out_valid_reg;
    logic       adv;
    logic       in_acc;
    logic       load_acc;
    logic       sample_acc;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv && !(s_axis_tuser == OP_LOAD && (vld_reg[1] || vld_reg[2]));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load_acc      = in_acc && s_axis_tuser == OP_LOAD;
    assign sample_acc    = in_acc && s_axis_tuser == OP_SAMPLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[8:1], sample_acc};
            out_valid_reg <= vld_reg[9];
        end
    end

    // table copies
    logic [PERM_W-1:0] l1_d0, l1_d1;
    logic [PERM_W-1:0] l2a_d0, l2a_d1, l2b_d0, l2b_d1;
    logic [PERM_W-1:0] l3_d0 [4];
    logic [PERM_W-1:0] l3_d1 [4];
    logic [IW-1:0]     l3_addr [4];
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     l1_addr;
    logic [IW-1:0]     a_next, b_next;

    logic [IW-1:0] s1_cy_reg, s1_cz_reg, s2_cz_reg;

    assign wr_addr = IW'(in_index);
    assign l1_addr = in_cx_full[IW-1:0];
    assign a_next  = IW'(l1_d0) + s1_cy_reg;
    assign b_next  = IW'(l1_d1) + s1_cy_reg;

    assign l3_addr[0] = IW'(l2a_d0) + s2_cz_reg;
    assign l3_addr[1] = IW'(l2b_d0) + s2_cz_reg;
    assign l3_addr[2] = IW'(l2a_d1) + s2_cz_reg;
    assign l3_addr[3] = IW'(l2b_d1) + s2_cz_reg;

    gn3_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l1 (
        .clk(clk), .wr_en(load_acc), .wr_addr(wr_addr), .wr_data(in_value),
        .rd_en(adv), .rd_addr0(l1_addr), .rd_addr1(l1_addr + IW'(1)),
        .rd_data0(l1_d0), .rd_data1(l1_d1)
    );

    gn3_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l2a (
        .clk(clk), .wr_en(load_acc), .wr_addr(wr_addr), .wr_data(in_value),
        .rd_en(adv), .rd_addr0(a_next), .rd_addr1(a_next + IW'(1)),
        .rd_data0(l2a_d0), .rd_data1(l2a_d1)
    );

    gn3_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l2b (
        .clk(clk), .wr_en(load_acc), .wr_addr(wr_addr), .wr_data(in_value),
        .rd_en(adv), .rd_addr0(b_next), .rd_addr1(b_next + IW'(1)),
        .rd_data0(l2b_d0), .rd_data1(l2b_d1)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_l3
        gn3_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l3 (
            .clk(clk), .wr_en(load_acc), .wr_addr(wr_addr), .wr_data(in_value),
            .rd_en(adv), .rd_addr0(l3_addr[g]), .rd_addr1(l3_addr[g] + IW'(1)),
            .rd_data0(l3_d0[g]), .rd_data1(l3_d1[g])
        );
    end

    // stage registers
    logic signed [W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [W-1:0] s2_x_reg, s2_y_reg, s2_z_reg;
    logic signed [W-1:0] s3_x_reg, s3_y_reg, s3_z_reg;
    logic signed [P-1:0] s2_tt_reg [3];
    logic signed [P-1:0] s2_tm_reg [3];
    logic signed [W-1:0] s3_t3_reg [3];
    logic signed [W-1:0] s3_in_reg [3];
    logic signed [W-1:0] s4_f_reg  [3];
    logic signed [W-1:0] s5_f_reg  [3];
    logic signed [W-1:0] s6_f_reg  [3];
    logic signed [W-1:0] s7_f_reg  [3];
    logic signed [W-1:0] s8_f_reg  [3];
    logic signed [W-1:0] s4_g_reg  [8];
    logic signed [W-1:0] s5_a_reg  [4];
    logic signed [P-1:0] s5_p_reg  [4];
    logic signed [W-1:0] s6_l_reg  [4];
    logic signed [W-1:0] s7_a_reg  [2];
    logic signed [P-1:0] s7_p_reg  [2];
    logic signed [W-1:0] s8_l_reg  [2];
    logic signed [W-1:0] s9_a_reg;
    logic signed [P-1:0] s9_p_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic signed [W-1:0] s1_t [3];
    logic signed [W-1:0] s2_t [3];
    logic signed [W-1:0] s2_t2 [3];
    logic signed [P-1:0] t3_prod [3];
    logic signed [P-1:0] fade_prod [3];
    logic signed [W-1:0] hx [2];
    logic signed [W-1:0] hy [2];
    logic signed [W-1:0] hz [2];
    logic [PERM_W-1:0]   hash [8];
    logic signed [W-1:0] grad_next [8];
    logic signed [W-1:0] sum_next;
    logic [OUT_W-1:0]    out_next;

    assign s1_t[0] = s1_x_reg;
    assign s1_t[1] = s1_y_reg;
    assign s1_t[2] = s1_z_reg;
    assign s2_t[0] = s2_x_reg;
    assign s2_t[1] = s2_y_reg;
    assign s2_t[2] = s2_z_reg;

    assign hx[0] = s3_x_reg;
    assign hx[1] = s3_x_reg - ONE;
    assign hy[0] = s3_y_reg;
    assign hy[1] = s3_y_reg - ONE;
    assign hz[0] = s3_z_reg;
    assign hz[1] = s3_z_reg - ONE;

    assign hash[0] = l3_d0[0];
    assign hash[1] = l3_d0[1];
    assign hash[2] = l3_d0[2];
    assign hash[3] = l3_d0[3];
    assign hash[4] = l3_d1[0];
    assign hash[5] = l3_d1[1];
    assign hash[6] = l3_d1[2];
    assign hash[7] = l3_d1[3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_t2[i]     = W'(s2_tt_reg[i] >>> FRAC_BITS);
            t3_prod[i]   = s2_t2[i] * s2_t[i];
            fade_prod[i] = s3_t3_reg[i] * s3_in_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            grad_next[i] = grad(hash[i], hx[i % 2], hy[(i / 2) % 2], hz[i / 4]);
        end
    end

    assign sum_next = s9_a_reg + W'(s9_p_reg >>> FRAC_BITS);

    always_comb
    begin
        if (sum_next > LIM)
        begin
            out_next = OUT_W'(LIM);
        end
        else if (sum_next < -LIM)
        begin
            out_next = OUT_W'(-LIM);
        end
        else
        begin
            out_next = OUT_W'(sum_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg  <= W'({1'b0, in_x[FRAC_BITS-1:0]});
            s1_y_reg  <= W'({1'b0, in_y[FRAC_BITS-1:0]});
            s1_z_reg  <= W'({1'b0, in_z[FRAC_BITS-1:0]});
            s1_cy_reg <= in_cy_full[IW-1:0];
            s1_cz_reg <= in_cz_full[IW-1:0];

            s2_x_reg  <= s1_x_reg;
            s2_y_reg  <= s1_y_reg;
            s2_z_reg  <= s1_z_reg;
            s2_cz_reg <= s1_cz_reg;
            s3_x_reg  <= s2_x_reg;
            s3_y_reg  <= s2_y_reg;
            s3_z_reg  <= s2_z_reg;

            for (int i = 0; i < 3; i++)
            begin
                s2_tt_reg[i] <= s1_t[i] * s1_t[i];
                s2_tm_reg[i] <= s1_t[i] * ((s1_t[i] <<< 2) + (s1_t[i] <<< 1) - FIFTEEN);
                s3_t3_reg[i] <= W'(t3_prod[i] >>> FRAC_BITS);
                s3_in_reg[i] <= W'(s2_tm_reg[i] >>> FRAC_BITS) + TEN;
                s4_f_reg[i]  <= W'(fade_prod[i] >>> FRAC_BITS);
                s5_f_reg[i]  <= s4_f_reg[i];
                s6_f_reg[i]  <= s5_f_reg[i];
                s7_f_reg[i]  <= s6_f_reg[i];
                s8_f_reg[i]  <= s7_f_reg[i];
            end

            for (int i = 0; i < 8; i++)
            begin
                s4_g_reg[i] <= grad_next[i];
            end

            for (int i = 0; i < 4; i++)
            begin
                s5_a_reg[i] <= s4_g_reg[2*i];
                s5_p_reg[i] <= s4_f_reg[0] * (s4_g_reg[2*i+1] - s4_g_reg[2*i]);
                s6_l_reg[i] <= s5_a_reg[i] + W'(s5_p_reg[i] >>> FRAC_BITS);
            end

            for (int i = 0; i < 2; i++)
            begin
                s7_a_reg[i] <= s6_l_reg[2*i];
                s7_p_reg[i] <= s6_f_reg[1] * (s6_l_reg[2*i+1] - s6_l_reg[2*i]);
                s8_l_reg[i] <= s7_a_reg[i] + W'(s7_p_reg[i] >>> FRAC_BITS);
            end

            s9_a_reg     <= s8_l_reg[0];
            s9_p_reg     <= s8_f_reg[2] * (s8_l_reg[1] - s8_l_reg[0]);
            out_data_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TD_W'(out_data_reg);

endmodule

`default_nettype wire

FILE: rtl/gn3_checker.sv
// Port-level checks for the 3D gradient noise core, attached by bind.
// Depends on gn3_pkg and gradient_noise_3d_core.
`default_nettype none

module gn3_checker import gn3_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int OUT_W    = FRAC_BITS + 3,
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                s_axis_tuser,   // operation
    input logic [IN_TD_W-1:0]  s_axis_tdata,   // table_index, table_value, coord_x, y, z
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_TD_W-1:0] m_axis_tdata    // noise_value, zero fill
);

    localparam int LIM = 2 << FRAC_BITS;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[OUT_W-1:0]) <= LIM
                       && $signed(m_axis_tdata[OUT_W-1:0]) >= -LIM)
        else $error("result outside saturation range");

    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while pipeline stalled");

    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> OUT_W) == '0)
        else $error("result fill bits not zero");

endmodule

bind gradient_noise_3d_core gn3_checker #(.FRAC_BITS(FRAC_BITS)) u_gn3_checker (.*);

`default_nettype wire
